@@ src/edc_pkg.sv @@
package edc_pkg;

  localparam int FLOORS  = 6;
  localparam int FLOOR_W = 3;
  localparam int CNT_W   = 16;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [FLOOR_W-1:0] FLOOR_TOP = FLOOR_W'(FLOORS - 1);
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  localparam logic [CNT_W-1:0] TBF_RESET = CNT_W'(3000);
  localparam logic [CNT_W-1:0] TDO_RESET = CNT_W'(5000);

  typedef logic [FLOORS-1:0] mask_t;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_HALL = 2'd1,
    FUNC_CAR  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_UP   = 2'd1,
    MOTOR_DOWN = 2'd2
  } motor_t;

  // register index, decoded from paddr[2]
  typedef enum logic {
    REG_TICKS_BETWEEN_FLOORS = 1'b0,
    REG_TICKS_DOOR_OPEN      = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] ticks_between_floors;
    logic [CNT_W-1:0] ticks_door_open;
  } edc_cfg_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] floor_reg;
    logic               dir_up;
    logic               halted;
    logic               doors_shut;
    logic               door_timing;
    logic [CNT_W-1:0]   travel_count;
    logic [CNT_W-1:0]   door_count;
    mask_t              hall_calls;
    mask_t              car_calls;
  } edc_state_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] floor_now;
    logic               going_up;
    logic [1:0]         motor_cmd;
    logic               doors_open;
    mask_t              hall_mask;
    mask_t              car_mask;
  } edc_result_t;

endpackage

@@ src/edc_in_if.sv @@
interface edc_in_if;
  import edc_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [FLOOR_W-1:0] call_floor;

  modport source (output valid, output func, output call_floor, input ready);
  modport sink   (input valid, input func, input call_floor, output ready);
endinterface

@@ src/edc_out_if.sv @@
interface edc_out_if;
  import edc_pkg::*;

  logic               valid;
  logic               ready;
  logic [FLOOR_W-1:0] floor_now;
  logic               going_up;
  logic [1:0]         motor_cmd;
  logic               doors_open;
  mask_t              hall_mask;
  mask_t              car_mask;

  modport source (output valid, output floor_now, output going_up, output motor_cmd,
                  output doors_open, output hall_mask, output car_mask, input ready);
  modport sink   (input valid, input floor_now, input going_up, input motor_cmd,
                  input doors_open, input hall_mask, input car_mask, output ready);
endinterface

@@ src/elevator_dispatch_controller.sv @@
// Single-car elevator controller with collective dispatch.
//
// Input channel (in_ch): one word per event. func selects a 1 ms tick, a
// hall call or a car call; call_floor names the floor of a call. Calls for
// floors past the top, car calls for the current floor and func code 3
// change nothing but still return a word.
// Result channel (out_ch): exactly one word per event, in order: floor,
// direction, motor command, door state and both pending-call masks.
// Config port (APB): reg 0 at 0x0 ticks_between_floors, reg 1 at 0x4
// ticks_door_open, low 16 bits used. pready is tied high; write only
// while no events are in flight.
//
// The event is applied to the controller state and the result word is
// captured in the output register at the same edge. Throughput is one
// event per clock while out_ch is not stalled; the path is the dispatch
// priority logic on the call masks plus two 16-bit timer compares.
// Stall: in_ch.ready drops only while the output register is full and
// out_ch.ready is low; it is taken again in the cycle the word leaves.
// Reset (synchronous, rst_n low): car at floor 0 halted, doors shut,
// heading up, masks and timers clear, registers back to 3000 / 5000 ticks.
module elevator_dispatch_controller
  import edc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  edc_in_if.sink            in_ch,
  edc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  edc_cfg_t    cfg;
  edc_state_t  state_r;
  edc_state_t  state_nxt;
  edc_result_t res_nxt;
  edc_result_t res_r;
  logic        out_valid_r;
  logic        accept;

  edc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  edc_step u_step (
    .cur        (state_r),
    .cfg        (cfg),
    .func       (in_ch.func),
    .call_floor (in_ch.call_floor),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  // output register empty, or being drained this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.floor_reg    <= '0;
      state_r.dir_up       <= 1'b1;
      state_r.halted       <= 1'b1;
      state_r.doors_shut   <= 1'b1;
      state_r.door_timing  <= 1'b0;
      state_r.travel_count <= '0;
      state_r.door_count   <= '0;
      state_r.hall_calls   <= '0;
      state_r.car_calls    <= '0;
      out_valid_r          <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.floor_now  = res_r.floor_now;
  assign out_ch.going_up   = res_r.going_up;
  assign out_ch.motor_cmd  = res_r.motor_cmd;
  assign out_ch.doors_open = res_r.doors_open;
  assign out_ch.hall_mask  = res_r.hall_mask;
  assign out_ch.car_mask   = res_r.car_mask;

endmodule

@@ src/edc_cfg.sv @@
module edc_cfg
  import edc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output edc_cfg_t          cfg
);

  edc_cfg_t cfg_r;
  reg_idx_t sel;
  logic     wr_en;

  assign pready = 1'b1;
  assign sel    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_between_floors <= TBF_RESET;
      cfg_r.ticks_door_open      <= TDO_RESET;
    end else if (wr_en) begin
      unique case (sel)
        REG_TICKS_BETWEEN_FLOORS: cfg_r.ticks_between_floors <= pwdata[CNT_W-1:0];
        REG_TICKS_DOOR_OPEN:      cfg_r.ticks_door_open      <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      REG_TICKS_BETWEEN_FLOORS: prdata[CNT_W-1:0] = cfg_r.ticks_between_floors;
      REG_TICKS_DOOR_OPEN:      prdata[CNT_W-1:0] = cfg_r.ticks_door_open;
      default: ;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ src/edc_step.sv @@
module edc_step
  import edc_pkg::*;
(
  input  edc_state_t         cur,
  input  edc_cfg_t           cfg,
  input  logic [1:0]         func,
  input  logic [FLOOR_W-1:0] call_floor,
  output edc_state_t         nxt,
  output edc_result_t        res
);

  function automatic mask_t floor_bit(input logic [FLOOR_W-1:0] f);
    mask_t fb;
    fb = '0;
    if (32'(f) < FLOORS) fb = mask_t'(1) << f;
    return fb;
  endfunction

  // any call at this floor or beyond it in the given direction
  function automatic logic calls_toward(input edc_state_t s, input logic up);
    mask_t pending;
    mask_t here;
    mask_t below;
    mask_t region;
    pending = s.hall_calls | s.car_calls;
    here    = floor_bit(s.floor_reg);
    below   = here - mask_t'(1);
    region  = up ? ~below : (here | below);
    return (pending & region) != '0;
  endfunction

  function automatic edc_state_t open_doors(input edc_state_t s);
    edc_state_t o;
    o = s;
    o.doors_shut = 1'b0;
    if (!s.door_timing) begin
      o.door_count  = '0;
      o.door_timing = 1'b1;
    end
    return o;
  endfunction

  function automatic edc_state_t dispatch(input edc_state_t s);
    edc_state_t o;
    o = s;
    if ((s.hall_calls & floor_bit(s.floor_reg)) != '0) begin
      o = open_doors(s);
    end else if (calls_toward(s, s.dir_up)) begin
      o.halted       = 1'b0;
      o.travel_count = '0;
    end else if (calls_toward(s, !s.dir_up)) begin
      o.dir_up       = !s.dir_up;
      o.halted       = 1'b0;
      o.travel_count = '0;
    end
    return o;
  endfunction

  always_comb begin
    edc_state_t s;
    mask_t      b;
    mask_t      here;
    logic       fresh;

    s     = cur;
    b     = floor_bit(call_floor);
    fresh = 1'b0;
    here  = '0;

    unique case (func)
      FUNC_TICK: begin
        if (s.travel_count != CNT_MAX) s.travel_count = s.travel_count + CNT_W'(1);
        if (s.door_count != CNT_MAX)   s.door_count   = s.door_count + CNT_W'(1);

        if (!s.halted && s.doors_shut && s.travel_count >= cfg.ticks_between_floors) begin
          if (s.dir_up) begin
            if (s.floor_reg < FLOOR_TOP) s.floor_reg = s.floor_reg + FLOOR_W'(1);
          end else begin
            if (s.floor_reg != '0) s.floor_reg = s.floor_reg - FLOOR_W'(1);
          end
          here = floor_bit(s.floor_reg);
          if (((s.hall_calls | s.car_calls) & here) != '0) begin
            s.halted     = 1'b1;
            s.hall_calls = s.hall_calls & ~here;
            s.car_calls  = s.car_calls & ~here;
            s = open_doors(s);
          end
          if (s.doors_shut) s = dispatch(s);
        end

        if (s.door_timing && s.door_count >= cfg.ticks_door_open) begin
          here          = floor_bit(s.floor_reg);
          s.door_timing = 1'b0;
          s.doors_shut  = 1'b1;
          s.hall_calls  = s.hall_calls & ~here;
          s.car_calls   = s.car_calls & ~here;
          s = dispatch(s);
        end
      end
      FUNC_HALL: begin
        if (b != '0 && (s.hall_calls & b) == '0) begin
          s.hall_calls = s.hall_calls | b;
          fresh        = 1'b1;
        end
      end
      FUNC_CAR: begin
        if (b != '0 && call_floor != s.floor_reg && (s.car_calls & b) == '0) begin
          s.car_calls = s.car_calls | b;
          fresh       = 1'b1;
        end
      end
      default: ;
    endcase

    if (fresh && s.doors_shut && s.halted) s = dispatch(s);

    nxt = s;

    res.floor_now  = s.floor_reg;
    res.going_up   = s.dir_up;
    res.motor_cmd  = (!s.halted && s.doors_shut) ? (s.dir_up ? MOTOR_UP : MOTOR_DOWN)
                                                 : MOTOR_STOP;
    res.doors_open = !s.doors_shut;
    res.hall_mask  = s.hall_calls;
    res.car_mask   = s.car_calls;
  end

endmodule

@@ src/edc_checker.sv @@
module edc_checker
  import edc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FLOOR_W-1:0] out_floor_now,
  input logic [1:0]         out_motor_cmd,
  input logic               out_doors_open,
  input mask_t              out_car_mask
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted event gave no result word");

  a_doors_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_doors_open |-> out_motor_cmd == MOTOR_STOP)
    else $error("motor driven with doors open");

  a_no_car_call_here: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_car_mask[out_floor_now])
    else $error("car call pending at current floor");

endmodule

bind elevator_dispatch_controller edc_checker u_edc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_floor_now  (out_ch.floor_now),
  .out_motor_cmd  (out_ch.motor_cmd),
  .out_doors_open (out_ch.doors_open),
  .out_car_mask   (out_ch.car_mask)
);
